// ===== rtl/jsu_pkg.sv =====
package jsu_pkg;

   localparam int unsigned QDEPTH = 4;
   localparam int unsigned QPTR_W = $clog2(QDEPTH);
   localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

   localparam logic [7:0] REPLACEMENT_RESET = 8'h3F;
   localparam logic [7:0] ASCII_MAX         = 8'h7F;

   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_SLASH     = 8'h2F;
   localparam logic [7:0] CHAR_B         = 8'h62;
   localparam logic [7:0] CHAR_F         = 8'h66;
   localparam logic [7:0] CHAR_N         = 8'h6E;
   localparam logic [7:0] CHAR_R         = 8'h72;
   localparam logic [7:0] CHAR_T         = 8'h74;
   localparam logic [7:0] CHAR_U         = 8'h75;
   localparam logic [7:0] CHAR_BS        = 8'h08;
   localparam logic [7:0] CHAR_FF        = 8'h0C;
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_TAB       = 8'h09;

   typedef enum logic [2:0] {
      ST_BYTE     = 3'd0,
      ST_COMPLETE = 3'd1,
      ST_NO_QUOTE = 3'd2,
      ST_BAD_ESC  = 3'd3,
      ST_BAD_HEX  = 3'd4,
      ST_UNTERM   = 3'd5
   } status_type;

   typedef enum logic [4:0] {
      PH_OPEN = 5'b00001,
      PH_STR  = 5'b00010,
      PH_ESC  = 5'b00100,
      PH_HEX  = 5'b01000,
      PH_DONE = 5'b10000
   } phase_type;

   typedef struct packed {
      status_type status;
      logic [7:0] out_byte;
      logic       last_of_run;
   } entry_type;

endpackage

// ===== rtl/json_string_unescape.sv =====
// Channel   Direction  Handshake           Payload
// req_      in         req_valid/req_stall in_byte, end_of_frame
// rsp_      out        rsp_valid/rsp_stall status, out_byte, last_of_run
// csr_      in         csr_write_enable    csr_write_data (replacement byte)
//
// One input word is accepted per cycle while req_stall is low; it is decoded from the input register.
// The first result word appears on rsp_ once its input word has passed the input register and the output queue.
// A word yields up to two results, held in a four-entry output queue.
// The input stalls while a word waits in the input register and the queue holds
// more than two words.
// Reset is synchronous and returns the decoder to expecting an opening quote.
module json_string_unescape (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_frame,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);

   logic                          s1_valid_ff, s1_valid_in;
   logic [7:0]                    s1_byte_ff;
   logic                          s1_eof_ff;
   logic [7:0]                    replacement_ff;
   jsu_pkg::phase_type            phase_ff, phase_in;
   logic [1:0]                    hex_count_ff, hex_count_in;
   logic [15:0]                   hex_accum_ff, hex_accum_in;
   jsu_pkg::entry_type            q_ff [jsu_pkg::QDEPTH];
   logic [jsu_pkg::QPTR_W-1:0]    head_ff, head_in, tail_ff, tail_in;
   logic [jsu_pkg::QCNT_W-1:0]    count_ff, count_in;

   logic                          accept, room, proc, pop;
   logic                          emit0, ended, unterm;
   jsu_pkg::status_type           st0;
   logic [7:0]                    byte0;
   logic [15:0]                   accum_next;
   logic [3:0]                    hex_val;
   logic                          hex_ok;
   logic [7:0]                    esc_byte;
   logic                          esc_ok;
   jsu_pkg::entry_type            ent0, ent1;
   logic [1:0]                    push_n;
   jsu_pkg::entry_type            head_ent;

   assign room      = count_ff <= jsu_pkg::QCNT_W'(jsu_pkg::QDEPTH - 2);
   assign proc      = s1_valid_ff && room;
   assign req_stall = s1_valid_ff && !room;
   assign accept    = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (proc) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      priority if (s1_byte_ff >= 8'h30 && s1_byte_ff <= 8'h39) begin
         hex_val = s1_byte_ff[3:0];
      end else if ((s1_byte_ff >= 8'h61 && s1_byte_ff <= 8'h66)
                   || (s1_byte_ff >= 8'h41 && s1_byte_ff <= 8'h46)) begin
         hex_val = s1_byte_ff[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
   end

   always_comb begin
      esc_ok   = 1'b1;
      esc_byte = s1_byte_ff;
      unique case (s1_byte_ff)
         jsu_pkg::CHAR_QUOTE, jsu_pkg::CHAR_BACKSLASH, jsu_pkg::CHAR_SLASH: begin
            esc_byte = s1_byte_ff;
         end
         jsu_pkg::CHAR_B: esc_byte = jsu_pkg::CHAR_BS;
         jsu_pkg::CHAR_F: esc_byte = jsu_pkg::CHAR_FF;
         jsu_pkg::CHAR_N: esc_byte = jsu_pkg::CHAR_LF;
         jsu_pkg::CHAR_R: esc_byte = jsu_pkg::CHAR_CR;
         jsu_pkg::CHAR_T: esc_byte = jsu_pkg::CHAR_TAB;
         default:         esc_ok   = 1'b0;
      endcase
   end

   assign accum_next = {hex_accum_ff[11:0], hex_val};

   always_comb begin
      phase_in     = phase_ff;
      hex_count_in = hex_count_ff;
      hex_accum_in = hex_accum_ff;
      emit0        = 1'b0;
      ended        = 1'b0;
      st0          = jsu_pkg::ST_BYTE;
      byte0        = 8'd0;
      unique case (phase_ff)
         jsu_pkg::PH_OPEN: begin
            if (s1_byte_ff == jsu_pkg::CHAR_QUOTE) begin
               phase_in = jsu_pkg::PH_STR;
            end else begin
               emit0 = 1'b1;
               st0   = jsu_pkg::ST_NO_QUOTE;
               ended = 1'b1;
            end
         end
         jsu_pkg::PH_STR: begin
            priority if (s1_byte_ff == jsu_pkg::CHAR_QUOTE) begin
               emit0 = 1'b1;
               st0   = jsu_pkg::ST_COMPLETE;
               ended = 1'b1;
            end else if (s1_byte_ff == jsu_pkg::CHAR_BACKSLASH) begin
               phase_in = jsu_pkg::PH_ESC;
            end else begin
               emit0 = 1'b1;
               byte0 = s1_byte_ff;
            end
         end
         jsu_pkg::PH_ESC: begin
            priority if (esc_ok) begin
               emit0    = 1'b1;
               byte0    = esc_byte;
               phase_in = jsu_pkg::PH_STR;
            end else if (s1_byte_ff == jsu_pkg::CHAR_U) begin
               hex_count_in = 2'd0;
               hex_accum_in = 16'd0;
               phase_in     = jsu_pkg::PH_HEX;
            end else begin
               emit0 = 1'b1;
               st0   = jsu_pkg::ST_BAD_ESC;
               ended = 1'b1;
            end
         end
         jsu_pkg::PH_HEX: begin
            if (!hex_ok) begin
               emit0 = 1'b1;
               st0   = jsu_pkg::ST_BAD_HEX;
               ended = 1'b1;
            end else begin
               hex_accum_in = accum_next;
               if (hex_count_ff == 2'd3) begin
                  emit0        = 1'b1;
                  byte0        = (accum_next <= {8'd0, jsu_pkg::ASCII_MAX})
                                 ? accum_next[7:0] : replacement_ff;
                  hex_count_in = 2'd0;
                  phase_in     = jsu_pkg::PH_STR;
               end else begin
                  hex_count_in = hex_count_ff + 2'd1;
               end
            end
         end
         default: begin
            ended = 1'b1;
         end
      endcase
      if (ended) begin
         phase_in = jsu_pkg::PH_DONE;
      end
      if (s1_eof_ff) begin
         phase_in     = jsu_pkg::PH_OPEN;
         hex_count_in = 2'd0;
         hex_accum_in = 16'd0;
      end
   end

   assign unterm = !ended && s1_eof_ff;

   always_comb begin
      ent0.status      = st0;
      ent0.out_byte    = byte0;
      ent0.last_of_run = !unterm;
      ent1.status      = jsu_pkg::ST_UNTERM;
      ent1.out_byte    = 8'd0;
      ent1.last_of_run = 1'b1;
      if (!emit0) begin
         ent0 = ent1;
      end
      push_n = proc ? ({1'b0, emit0} + {1'b0, unterm}) : 2'd0;
   end

   assign tail_in  = tail_ff + jsu_pkg::QPTR_W'(push_n);
   assign head_in  = head_ff + jsu_pkg::QPTR_W'(pop);
   assign count_in = count_ff + jsu_pkg::QCNT_W'(push_n) - jsu_pkg::QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         replacement_ff <= jsu_pkg::REPLACEMENT_RESET;
         phase_ff       <= jsu_pkg::PH_OPEN;
         hex_count_ff   <= 2'd0;
         hex_accum_ff   <= 16'd0;
         head_ff        <= '0;
         tail_ff        <= '0;
         count_ff       <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (csr_write_enable) begin
            replacement_ff <= csr_write_data;
         end
         if (proc) begin
            phase_ff     <= phase_in;
            hex_count_ff <= hex_count_in;
            hex_accum_ff <= hex_accum_in;
         end
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_byte_ff <= req_in_byte;
         s1_eof_ff  <= req_end_of_frame;
      end
      if (push_n != 2'd0) begin
         q_ff[tail_ff] <= ent0;
      end
      if (push_n == 2'd2) begin
         q_ff[tail_ff + jsu_pkg::QPTR_W'(1)] <= ent1;
      end
   end

   assign head_ent        = q_ff[head_ff];
   assign rsp_valid       = count_ff != '0;
   assign rsp_status      = head_ent.status;
   assign rsp_out_byte    = head_ent.out_byte;
   assign rsp_last_of_run = head_ent.last_of_run;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= jsu_pkg::QCNT_W'(jsu_pkg::QDEPTH))
      else $error("Output queue count exceeds its depth.");

   a_phase_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(phase_ff))
      else $error("Phase register is not one-hot.");

   a_eof_reopens: assert property (@(posedge clock) disable iff (reset)
      proc && s1_eof_ff |=> phase_ff == jsu_pkg::PH_OPEN)
      else $error("End of frame did not return the decoder to its opening state.");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      proc |-> count_ff + jsu_pkg::QCNT_W'(push_n) <= jsu_pkg::QCNT_W'(jsu_pkg::QDEPTH))
      else $error("Output queue written beyond its depth.");

   a_zero_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != jsu_pkg::ST_BYTE |-> rsp_out_byte == 8'd0)
      else $error("Non-data result carries a non-zero byte.");

endmodule

// ===== sim/json_string_unescape_checker.sv =====
module json_string_unescape_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_frame,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [2:0] rsp_status,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_last_of_run,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data,
   output int         fail_count,
   output int         outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   jsu_pkg::phase_type decode_phase;
   logic [1:0]         digit_count;
   logic [15:0]        code_accum;
   logic [7:0]         replacement;
   jsu_pkg::entry_type decoded_q[$];
   int                 mismatch_total = 0;

   assign fail_count = mismatch_total;

   function automatic jsu_pkg::entry_type make_entry(input jsu_pkg::status_type s,
                                                     input logic [7:0] b);
      jsu_pkg::entry_type e;
      e.status      = s;
      e.out_byte    = b;
      e.last_of_run = 1'b0;
      return e;
   endfunction

   // Bit 4 flags a valid hex digit; bits 3:0 hold its value.
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
      if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 10)};
      if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 10)};
      return 5'b0_0000;
   endfunction

   task automatic decode_word(input logic [7:0] c, input logic eof);
      jsu_pkg::entry_type produced[$];
      logic               ended;
      logic [4:0]         nib;
      ended = 1'b0;
      case (decode_phase)
         jsu_pkg::PH_OPEN: begin
            if (c == jsu_pkg::CHAR_QUOTE) begin
               decode_phase = jsu_pkg::PH_STR;
            end else begin
               produced = {produced, make_entry(jsu_pkg::ST_NO_QUOTE, 8'h00)};
               ended = 1'b1;
            end
         end
         jsu_pkg::PH_STR: begin
            if (c == jsu_pkg::CHAR_QUOTE) begin
               produced = {produced, make_entry(jsu_pkg::ST_COMPLETE, 8'h00)};
               ended = 1'b1;
            end else if (c == jsu_pkg::CHAR_BACKSLASH) begin
               decode_phase = jsu_pkg::PH_ESC;
            end else begin
               produced = {produced, make_entry(jsu_pkg::ST_BYTE, c)};
            end
         end
         jsu_pkg::PH_ESC: begin
            decode_phase = jsu_pkg::PH_STR;
            case (c)
               jsu_pkg::CHAR_QUOTE, jsu_pkg::CHAR_BACKSLASH, jsu_pkg::CHAR_SLASH: begin
                  produced = {produced, make_entry(jsu_pkg::ST_BYTE, c)};
               end
               jsu_pkg::CHAR_B: begin
                  produced = {produced, make_entry(jsu_pkg::ST_BYTE, jsu_pkg::CHAR_BS)};
               end
               jsu_pkg::CHAR_F: begin
                  produced = {produced, make_entry(jsu_pkg::ST_BYTE, jsu_pkg::CHAR_FF)};
               end
               jsu_pkg::CHAR_N: begin
                  produced = {produced, make_entry(jsu_pkg::ST_BYTE, jsu_pkg::CHAR_LF)};
               end
               jsu_pkg::CHAR_R: begin
                  produced = {produced, make_entry(jsu_pkg::ST_BYTE, jsu_pkg::CHAR_CR)};
               end
               jsu_pkg::CHAR_T: begin
                  produced = {produced, make_entry(jsu_pkg::ST_BYTE, jsu_pkg::CHAR_TAB)};
               end
               jsu_pkg::CHAR_U: begin
                  digit_count  = 2'd0;
                  code_accum   = 16'h0000;
                  decode_phase = jsu_pkg::PH_HEX;
               end
               default: begin
                  produced = {produced, make_entry(jsu_pkg::ST_BAD_ESC, 8'h00)};
                  ended = 1'b1;
               end
            endcase
         end
         jsu_pkg::PH_HEX: begin
            nib = hex_nibble(c);
            if (!nib[4]) begin
               produced = {produced, make_entry(jsu_pkg::ST_BAD_HEX, 8'h00)};
               ended = 1'b1;
            end else begin
               code_accum = {code_accum[11:0], nib[3:0]};
               if (digit_count == 2'd3) begin
                  produced = {produced, make_entry(jsu_pkg::ST_BYTE,
                     (code_accum <= {8'h00, jsu_pkg::ASCII_MAX}) ? code_accum[7:0]
                                                                 : replacement)};
                  digit_count  = 2'd0;
                  decode_phase = jsu_pkg::PH_STR;
               end else begin
                  digit_count = digit_count + 2'd1;
               end
            end
         end
         default: begin
            ended = 1'b1;
         end
      endcase

      if (ended) begin
         decode_phase = jsu_pkg::PH_DONE;
      end else if (eof) begin
         produced = {produced, make_entry(jsu_pkg::ST_UNTERM, 8'h00)};
      end
      if (eof) begin
         decode_phase = jsu_pkg::PH_OPEN;
         digit_count  = 2'd0;
         code_accum   = 16'h0000;
      end
      if (produced.size() > 0) begin
         produced[produced.size() - 1].last_of_run = 1'b1;
      end
      decoded_q = {decoded_q, produced};
   endtask

   always @(posedge clock) begin
      jsu_pkg::entry_type want;
      if (reset) begin
         decode_phase = jsu_pkg::PH_OPEN;
         digit_count  = 2'd0;
         code_accum   = 16'h0000;
         replacement  = jsu_pkg::REPLACEMENT_RESET;
         decoded_q.delete();
      end else begin
         if (csr_write_enable) begin
            replacement = csr_write_data;
         end
         if (req_valid && !req_stall) begin
            decode_word(req_in_byte, req_end_of_frame);
         end
         if (rsp_valid && !rsp_stall) begin
            if (decoded_q.size() == 0) begin
               if (mismatch_total < 10) begin
                  $display("%0t: unexpected result word: status %0d byte %02h last %0b",
                           $realtime, rsp_status, rsp_out_byte, rsp_last_of_run);
               end
               mismatch_total++;
            end else begin
               want = decoded_q.pop_front();
               if (rsp_status !== want.status || rsp_out_byte !== want.out_byte ||
                   rsp_last_of_run !== want.last_of_run) begin
                  if (mismatch_total < 10) begin
                     $display("%0t: mismatch: expected status %0d byte %02h last %0b,",
                              $realtime, want.status, want.out_byte, want.last_of_run,
                              " got status %0d byte %02h last %0b",
                              rsp_status, rsp_out_byte, rsp_last_of_run);
                  end
                  mismatch_total++;
               end
            end
         end
      end
      outstanding <= decoded_q.size();
   end

endmodule

// ===== sim/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD  = 5;
   localparam int LIMIT_CYCLES = 500000;
   localparam int HOLD_CYCLES  = 200;
   localparam int SETTLE       = 4;

   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       req_valid        = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte      = 8'h00;
   logic       req_end_of_frame = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall        = 1'b0;
   logic [2:0] rsp_status;
   logic [7:0] rsp_out_byte;
   logic       rsp_last_of_run;
   logic       csr_write_enable = 1'b0;
   logic [7:0] csr_write_data   = 8'h00;
   int         fail_count;
   int         outstanding;

   int         idle_pct     = 0;
   int         stall_pct    = 0;
   int         holds_wanted = 0;
   int         holds_done   = 0;
   int         frame_useful;
   logic [7:0] frame_text[$];

   json_string_unescape u_dut (.*);

   json_string_unescape_checker u_checker (.*);

   always #(HALF_PERIOD) clock = ~clock;

   initial begin
      #(LIMIT_CYCLES * 2 * HALF_PERIOD);
      $display("TEST FAILED");
      $finish;
   end

   // The receiver stalls at random, and holds off completely when asked.
   initial begin
      forever begin
         @(posedge clock);
         if (holds_done < holds_wanted) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_done++;
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) return "0" + v;
      if ($urandom_range(1) == 0) return 8'("a" + v - 10);
      return 8'("A" + v - 10);
   endfunction

   function automatic bit is_hex_char(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic bit is_escape_letter(input logic [7:0] c);
      case (c)
         jsu_pkg::CHAR_QUOTE, jsu_pkg::CHAR_BACKSLASH, jsu_pkg::CHAR_SLASH, jsu_pkg::CHAR_B,
         jsu_pkg::CHAR_F, jsu_pkg::CHAR_N, jsu_pkg::CHAR_R, jsu_pkg::CHAR_T,
         jsu_pkg::CHAR_U: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic [7:0] pick_escape_letter();
      case ($urandom_range(7))
         0: return jsu_pkg::CHAR_QUOTE;
         1: return jsu_pkg::CHAR_BACKSLASH;
         2: return jsu_pkg::CHAR_SLASH;
         3: return jsu_pkg::CHAR_B;
         4: return jsu_pkg::CHAR_F;
         5: return jsu_pkg::CHAR_N;
         6: return jsu_pkg::CHAR_R;
         default: return jsu_pkg::CHAR_T;
      endcase
   endfunction

   task automatic add_byte(input logic [7:0] c);
      frame_text = {frame_text, c};
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   task automatic put_hex_escape(input logic [15:0] code);
      add_byte(jsu_pkg::CHAR_BACKSLASH);
      add_byte(jsu_pkg::CHAR_U);
      for (int i = 3; i >= 0; i--) add_byte(hex_char(code[i*4 +: 4]));
   endtask

   task automatic append_piece();
      int         r;
      logic [7:0] c;
      r = $urandom_range(9);
      if (r < 6) begin
         do c = 8'($urandom); while (c == jsu_pkg::CHAR_QUOTE || c == jsu_pkg::CHAR_BACKSLASH);
         add_byte(c);
      end else if (r < 8) begin
         add_byte(jsu_pkg::CHAR_BACKSLASH);
         add_byte(pick_escape_letter());
      end else if ($urandom_range(1) == 0) begin
         put_hex_escape(16'($urandom_range(0, 255)));
      end else begin
         put_hex_escape(16'($urandom));
      end
   endtask

   // Mostly well-formed strings with random content; the rest is noise, bad
   // escapes, bad hex digits and frames that stop inside the string.
   task automatic build_frame();
      int         kind;
      logic [7:0] c;
      kind = $urandom_range(99);
      frame_text.delete();
      if (kind < 8) begin
         repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
         frame_useful = frame_text.size();
         return;
      end
      add_byte(jsu_pkg::CHAR_QUOTE);
      repeat ($urandom_range(0, 10)) append_piece();
      if (kind < 14) begin
         add_byte(jsu_pkg::CHAR_BACKSLASH);
         do c = 8'($urandom); while (is_escape_letter(c));
         add_byte(c);
      end else if (kind < 20) begin
         add_byte(jsu_pkg::CHAR_BACKSLASH);
         add_byte(jsu_pkg::CHAR_U);
         repeat ($urandom_range(0, 3)) add_byte(hex_char(4'($urandom)));
         do c = 8'($urandom); while (is_hex_char(c));
         add_byte(c);
      end else if (kind < 30) begin
         r_trunc: begin
            int how;
            how = $urandom_range(2);
            if (how >= 1) add_byte(jsu_pkg::CHAR_BACKSLASH);
            if (how == 2) begin
               add_byte(jsu_pkg::CHAR_U);
               repeat ($urandom_range(0, 3)) add_byte(hex_char(4'($urandom)));
            end
         end
         frame_useful = frame_text.size();
         return;
      end else begin
         add_byte(jsu_pkg::CHAR_QUOTE);
      end
      frame_useful = frame_text.size();
      if ($urandom_range(3) == 0) begin
         repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
      end
   endtask

   task automatic send_word(input logic [7:0] c, input logic eof);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_in_byte      <= c;
      req_end_of_frame <= eof;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_frame();
      foreach (frame_text[i]) send_word(frame_text[i], i == frame_text.size() - 1);
   endtask

   task automatic random_frames(input int words);
      int sent;
      sent = 0;
      while (sent < words) begin
         build_frame();
         send_frame();
         sent += frame_useful;
      end
   endtask

   // The register is only written once every expected word has arrived and the
   // block has had time to finish words that give no result.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_replacement(input logic [7:0] v);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      frame_text.delete();
      add_byte(jsu_pkg::CHAR_QUOTE);
      add_byte(8'h00);
      add_byte(8'hFF);
      push_text("\\b");
      put_hex_escape(16'h007F);
      put_hex_escape(16'h0080);
      push_text("\"x");
      send_frame();
      frame_text.delete();
      push_text("Q");
      send_frame();
      frame_text.delete();
      push_text("\"\\");
      send_frame();
      frame_text.delete();
      push_text("\"\\q");
      send_frame();
      frame_text.delete();
      push_text("\"\\u1g\"");
      send_frame();
      frame_text.delete();
      push_text("\"\\u00");
      send_frame();
      frame_text.delete();
      push_text("\"z");
      send_frame();

      drain();
      write_replacement(8'h00);
      random_frames(330);

      drain();
      write_replacement(8'hFF);
      idle_pct = 83;
      random_frames(330);

      drain();
      write_replacement(8'($urandom));
      idle_pct  = 0;
      stall_pct = 83;
      random_frames(330);

      drain();
      write_replacement(8'($urandom));
      idle_pct  = 21;
      stall_pct = 21;
      random_frames(330);

      drain();
      write_replacement(jsu_pkg::REPLACEMENT_RESET);
      idle_pct     = 0;
      stall_pct    = 0;
      holds_wanted = 1;
      random_frames(150);

      drain();
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
